### hdl/i2cm_pkg.sv
// Package for the I2C master transaction engine.
// Holds the phase encoding, command mode codes and fixed constants.
// No dependencies.
package i2cm_pkg;

    // Transaction phase, one-hot
    typedef enum logic [14:0] {
        PH_IDLE      = 15'b000000000000001,
        PH_START     = 15'b000000000000010,
        PH_RSTART    = 15'b000000000000100,
        PH_SEND_DEV  = 15'b000000000001000,
        PH_SEND_REG  = 15'b000000000010000,
        PH_SEND_RDEV = 15'b000000000100000,
        PH_SEND_DATA = 15'b000000001000000,
        PH_ACK_DEV   = 15'b000000010000000,
        PH_ACK_REG   = 15'b000000100000000,
        PH_ACK_RDEV  = 15'b000001000000000,
        PH_ACK_DATA  = 15'b000010000000000,
        PH_READ      = 15'b000100000000000,
        PH_MACK      = 15'b001000000000000,
        PH_WWAIT     = 15'b010000000000000,
        PH_STOP      = 15'b100000000000000
    } phase_t;

    // Command mode codes
    localparam logic [1:0] MODE_PROBE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    // Slot step codes within one bus operation
    localparam logic [1:0] SUB_FIRST  = 2'd0;
    localparam logic [1:0] SUB_MID    = 2'd1;
    localparam logic [1:0] SUB_LAST   = 2'd2;

    localparam logic [7:0]  MSB_MASK        = 8'h80;
    localparam logic [3:0]  BYTE_BITS       = 4'd8;
    localparam logic [3:0]  LAST_BIT        = 4'd7;
    localparam logic [15:0] SLOT_TICKS_INIT = 16'd100;

endpackage

### hdl/i2c_master_transaction_engine.sv
// I2C master transaction engine: probe, register read and register write.
// One input transfer per bus tick, one result transfer per input transfer.
// Depends on i2cm_pkg.
//
//  channel   handshake               payload
//  -------   ---------------------   ---------------------------------------------
//  input     s_valid / s_ready       s_cmd_valid s_mode s_dev_addr s_reg_addr
//                                    s_byte_count s_write_byte s_write_valid
//                                    s_sda_level s_scl_level
//  result    m_valid / m_ready       m_scl_drive m_sda_drive m_read_byte m_read_valid
//                                    m_read_last m_write_request m_busy_res
//                                    m_done_res m_device_present
//  config    cfg_valid / cfg_ready   cfg_data (slot_ticks)
//
// For each input transfer, the next state and the result are computed
// from the state registers and the input, and both are registered at the edge.
// The result register drains independently; s_ready stays high while it is empty
// or being taken, so a transfer can enter every cycle when m_ready is high.
// Synchronous active-low reset clears the state, the result valid and slot_ticks
// (back to 100). cfg_ready is always high.
module i2c_master_transaction_engine #(
    parameter int SLOT_COUNT_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd_valid,
    input  logic [1:0]  s_mode,
    input  logic [7:0]  s_dev_addr,
    input  logic [7:0]  s_reg_addr,
    input  logic [7:0]  s_byte_count,
    input  logic [7:0]  s_write_byte,
    input  logic        s_write_valid,
    input  logic        s_sda_level,
    input  logic        s_scl_level,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_scl_drive,
    output logic        m_sda_drive,
    output logic [7:0]  m_read_byte,
    output logic        m_read_valid,
    output logic        m_read_last,
    output logic        m_write_request,
    output logic        m_busy_res,
    output logic        m_done_res,
    output logic        m_device_present
);

    localparam int CW = SLOT_COUNT_WIDTH + 1;
    localparam int TW = 17;
    localparam int MW = (CW > TW) ? CW : TW;

    // state
    i2cm_pkg::phase_t              phase_reg, phase_next;
    logic [SLOT_COUNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic [1:0]                    sub_reg, sub_next;
    logic [3:0]                    bidx_reg, bidx_next;
    logic [7:0]                    shift_reg, shift_next;
    logic [7:0]                    bleft_reg, bleft_next;
    logic [7:0]                    dev_reg, dev_next;
    logic [7:0]                    regb_reg, regb_next;
    logic [1:0]                    kind_reg, kind_next;
    logic                          ack_reg, ack_next;
    logic [15:0]                   slot_ticks_reg;

    // result register
    logic        m_valid_reg;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic [7:0]  rbyte_reg, rbyte_next;
    logic        rvalid_reg, rvalid_next;
    logic        rlast_reg, rlast_next;
    logic        wreq_reg, wreq_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        pres_reg, pres_next;

    // working values after a possible command start
    i2cm_pkg::phase_t              ph;
    logic [SLOT_COUNT_WIDTH-1:0]   cnt;
    logic [1:0]                    sub;
    logic [3:0]                    bidx;
    logic [3:0]                    bidx_inc;
    logic [7:0]                    shft;
    logic [7:0]                    bleft;
    logic [7:0]                    bleft_dec;
    logic                          ack;
    logic                          cmd_take;
    logic                          bus_busy;
    logic                          start;
    logic [15:0]                   ticks;
    logic [MW-1:0]                 cnt_inc_ext;
    logic [MW-1:0]                 ticks_ext;
    logic                          slot_end;
    logic [1:0]                    last_sub;
    logic                          s_take;

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_take    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // command decode
    assign cmd_take = (phase_reg == i2cm_pkg::PH_IDLE) && s_cmd_valid
                      && (s_mode != i2cm_pkg::MODE_NONE);
    assign bus_busy = (s_mode == i2cm_pkg::MODE_PROBE) && !(s_sda_level && s_scl_level);
    assign start    = cmd_take && !bus_busy;

    assign ph    = start ? i2cm_pkg::PH_START : phase_reg;
    assign cnt   = start ? '0 : cnt_reg;
    assign sub   = start ? i2cm_pkg::SUB_FIRST : sub_reg;
    assign bidx  = start ? 4'd0 : bidx_reg;
    assign shft  = start ? 8'd0 : shift_reg;
    assign bleft = start ? s_byte_count : bleft_reg;
    assign ack   = start ? 1'b0 : ack_reg;

    assign bidx_inc  = bidx + 4'd1;
    assign bleft_dec = bleft - 8'd1;

    // slot timing: zero ticks behaves as one
    assign ticks       = (slot_ticks_reg == 16'd0) ? 16'd1 : slot_ticks_reg;
    assign cnt_inc_ext = MW'(cnt) + MW'(1);
    assign ticks_ext   = MW'(ticks);
    assign slot_end    = (cnt_inc_ext >= ticks_ext) || (cnt == {SLOT_COUNT_WIDTH{1'b1}});
    assign last_sub    = (ph == i2cm_pkg::PH_READ) ? i2cm_pkg::SUB_MID : i2cm_pkg::SUB_LAST;

    // next state and result
    always_comb begin
        phase_next  = ph;
        cnt_next    = cnt;
        sub_next    = sub;
        bidx_next   = bidx;
        shift_next  = shft;
        bleft_next  = bleft;
        dev_next    = start ? s_dev_addr : dev_reg;
        regb_next   = start ? s_reg_addr : regb_reg;
        kind_next   = start ? s_mode : kind_reg;
        ack_next    = ack;

        scl_next    = 1'b1;
        sda_next    = 1'b1;
        rbyte_next  = 8'd0;
        rvalid_next = 1'b0;
        rlast_next  = 1'b0;
        wreq_next   = 1'b0;
        busy_next   = 1'b0;
        done_next   = cmd_take && bus_busy;
        pres_next   = 1'b0;

        if (ph != i2cm_pkg::PH_IDLE) begin
            busy_next = 1'b1;

            // pin levels for this tick
            case (ph)
                i2cm_pkg::PH_START, i2cm_pkg::PH_RSTART: begin
                    scl_next = (sub != i2cm_pkg::SUB_LAST);
                    sda_next = (sub == i2cm_pkg::SUB_FIRST);
                end
                i2cm_pkg::PH_SEND_DEV, i2cm_pkg::PH_SEND_REG,
                i2cm_pkg::PH_SEND_RDEV, i2cm_pkg::PH_SEND_DATA: begin
                    scl_next = (sub == i2cm_pkg::SUB_MID);
                    sda_next = ((shft & i2cm_pkg::MSB_MASK) != 8'd0)
                               || ((sub == i2cm_pkg::SUB_LAST) && (bidx == i2cm_pkg::LAST_BIT));
                end
                i2cm_pkg::PH_ACK_DEV, i2cm_pkg::PH_ACK_REG,
                i2cm_pkg::PH_ACK_RDEV, i2cm_pkg::PH_ACK_DATA: begin
                    scl_next = (sub == i2cm_pkg::SUB_MID);
                end
                i2cm_pkg::PH_READ: begin
                    scl_next = (sub == i2cm_pkg::SUB_FIRST);
                end
                i2cm_pkg::PH_MACK: begin
                    scl_next = (sub == i2cm_pkg::SUB_MID);
                    sda_next = (bleft == 8'd0);
                end
                i2cm_pkg::PH_WWAIT: begin
                    scl_next  = 1'b0;
                    wreq_next = 1'b1;
                end
                default: begin
                    scl_next = (sub != i2cm_pkg::SUB_FIRST);
                    sda_next = (sub == i2cm_pkg::SUB_LAST);
                end
            endcase

            if (ph == i2cm_pkg::PH_WWAIT) begin
                // wait for the next write data byte
                if (s_write_valid) begin
                    phase_next = i2cm_pkg::PH_SEND_DATA;
                    sub_next   = i2cm_pkg::SUB_FIRST;
                    cnt_next   = '0;
                    bidx_next  = 4'd0;
                    shift_next = s_write_byte;
                end
            end else if (!slot_end) begin
                cnt_next = cnt + SLOT_COUNT_WIDTH'(1);
            end else begin
                cnt_next = '0;
                if ((ph == i2cm_pkg::PH_ACK_DEV || ph == i2cm_pkg::PH_ACK_REG
                     || ph == i2cm_pkg::PH_ACK_RDEV || ph == i2cm_pkg::PH_ACK_DATA)
                    && sub == i2cm_pkg::SUB_MID) begin
                    ack_next = !s_sda_level;
                end
                if (ph == i2cm_pkg::PH_READ && sub == i2cm_pkg::SUB_FIRST) begin
                    shift_next = {shft[6:0], s_sda_level};
                end
                if (sub < last_sub) begin
                    sub_next = sub + 2'd1;
                end else begin
                    sub_next = i2cm_pkg::SUB_FIRST;
                    // end of one bus operation
                    case (ph)
                        i2cm_pkg::PH_START: begin
                            phase_next = i2cm_pkg::PH_SEND_DEV;
                            bidx_next  = 4'd0;
                            shift_next = dev_reg;
                        end
                        i2cm_pkg::PH_RSTART: begin
                            phase_next = i2cm_pkg::PH_SEND_RDEV;
                            bidx_next  = 4'd0;
                            shift_next = dev_reg | 8'd1;
                        end
                        i2cm_pkg::PH_SEND_DEV, i2cm_pkg::PH_SEND_REG,
                        i2cm_pkg::PH_SEND_RDEV, i2cm_pkg::PH_SEND_DATA: begin
                            shift_next = {shft[6:0], 1'b0};
                            bidx_next  = bidx_inc;
                            if (bidx_inc >= i2cm_pkg::BYTE_BITS) begin
                                bidx_next  = 4'd0;
                                shift_next = 8'd0;
                                case (ph)
                                    i2cm_pkg::PH_SEND_DEV:  phase_next = i2cm_pkg::PH_ACK_DEV;
                                    i2cm_pkg::PH_SEND_REG:  phase_next = i2cm_pkg::PH_ACK_REG;
                                    i2cm_pkg::PH_SEND_RDEV: phase_next = i2cm_pkg::PH_ACK_RDEV;
                                    default:                phase_next = i2cm_pkg::PH_ACK_DATA;
                                endcase
                            end
                        end
                        i2cm_pkg::PH_ACK_DEV: begin
                            if (kind_reg == i2cm_pkg::MODE_PROBE) begin
                                phase_next = i2cm_pkg::PH_STOP;
                                bidx_next  = 4'd0;
                                shift_next = 8'd0;
                            end else if (ack) begin
                                phase_next = i2cm_pkg::PH_SEND_REG;
                                bidx_next  = 4'd0;
                                shift_next = regb_reg;
                            end
                        end
                        i2cm_pkg::PH_ACK_REG: begin
                            if (ack) begin
                                bidx_next  = 4'd0;
                                shift_next = 8'd0;
                                if (kind_reg == i2cm_pkg::MODE_READ) begin
                                    phase_next = i2cm_pkg::PH_RSTART;
                                end else if (bleft != 8'd0) begin
                                    phase_next = i2cm_pkg::PH_WWAIT;
                                end else begin
                                    phase_next = i2cm_pkg::PH_STOP;
                                end
                            end
                        end
                        i2cm_pkg::PH_ACK_RDEV: begin
                            if (ack) begin
                                bidx_next  = 4'd0;
                                shift_next = 8'd0;
                                phase_next = (bleft != 8'd0) ? i2cm_pkg::PH_READ
                                                             : i2cm_pkg::PH_STOP;
                            end
                        end
                        i2cm_pkg::PH_ACK_DATA: begin
                            if (ack) begin
                                bleft_next = bleft_dec;
                                bidx_next  = 4'd0;
                                shift_next = 8'd0;
                                phase_next = (bleft_dec != 8'd0) ? i2cm_pkg::PH_WWAIT
                                                                 : i2cm_pkg::PH_STOP;
                            end
                        end
                        i2cm_pkg::PH_READ: begin
                            bidx_next = bidx_inc;
                            if (bidx_inc >= i2cm_pkg::BYTE_BITS) begin
                                bleft_next  = bleft_dec;
                                rbyte_next  = shft;
                                rvalid_next = 1'b1;
                                rlast_next  = (bleft_dec == 8'd0);
                                phase_next  = i2cm_pkg::PH_MACK;
                                bidx_next   = 4'd0;
                            end
                        end
                        i2cm_pkg::PH_MACK: begin
                            bidx_next  = 4'd0;
                            shift_next = 8'd0;
                            phase_next = (bleft != 8'd0) ? i2cm_pkg::PH_READ
                                                         : i2cm_pkg::PH_STOP;
                        end
                        default: begin
                            done_next  = 1'b1;
                            pres_next  = (kind_reg == i2cm_pkg::MODE_PROBE) ? ack : 1'b0;
                            phase_next = i2cm_pkg::PH_IDLE;
                            bidx_next  = 4'd0;
                        end
                    endcase
                end
            end
        end
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_ticks_reg <= i2cm_pkg::SLOT_TICKS_INIT;
        end else if (cfg_valid && cfg_ready) begin
            slot_ticks_reg <= cfg_data;
        end
    end

    // engine state, advanced once per input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= i2cm_pkg::PH_IDLE;
            cnt_reg   <= '0;
            sub_reg   <= i2cm_pkg::SUB_FIRST;
            bidx_reg  <= 4'd0;
            shift_reg <= 8'd0;
            bleft_reg <= 8'd0;
            dev_reg   <= 8'd0;
            regb_reg  <= 8'd0;
            kind_reg  <= i2cm_pkg::MODE_PROBE;
            ack_reg   <= 1'b0;
        end else if (s_take) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            sub_reg   <= sub_next;
            bidx_reg  <= bidx_next;
            shift_reg <= shift_next;
            bleft_reg <= bleft_next;
            dev_reg   <= dev_next;
            regb_reg  <= regb_next;
            kind_reg  <= kind_next;
            ack_reg   <= ack_next;
        end
    end

    // result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (s_take) begin
            scl_reg    <= scl_next;
            sda_reg    <= sda_next;
            rbyte_reg  <= rbyte_next;
            rvalid_reg <= rvalid_next;
            rlast_reg  <= rlast_next;
            wreq_reg   <= wreq_next;
            busy_reg   <= busy_next;
            done_reg   <= done_next;
            pres_reg   <= pres_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_scl_drive      = scl_reg;
    assign m_sda_drive      = sda_reg;
    assign m_read_byte      = rbyte_reg;
    assign m_read_valid     = rvalid_reg;
    assign m_read_last      = rlast_reg;
    assign m_write_request  = wreq_reg;
    assign m_busy_res       = busy_reg;
    assign m_done_res       = done_reg;
    assign m_device_present = pres_reg;

    // a received byte only appears during a transaction
    a_read_in_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_read_valid |-> m_busy_res && !m_done_res)
        else $error("read byte outside a transaction");

    // a present device is only reported with completion
    a_present_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_device_present |-> m_done_res && m_busy_res)
        else $error("device_present without done");

    // SCL is held low while waiting for write data
    a_wreq_scl_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_write_request |-> !m_scl_drive && m_sda_drive)
        else $error("write request with SCL released");

    // the engine is idle after a completed transaction
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_take && done_next |=> phase_reg == i2cm_pkg::PH_IDLE)
        else $error("engine not idle after done");

endmodule
